### rtl/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared opcodes, widths and pipeline stage types for the vector unit.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DOT   = 3'd3;
  localparam logic [2:0] OP_CROSS = 3'd4;
  localparam logic [2:0] OP_MAG   = 3'd5;
  localparam logic [2:0] OP_NORM  = 3'd6;

  localparam int RootW = 32;
  localparam int QuoW  = 18;
  localparam int DivW  = 49;

  localparam logic signed [31:0] RAW_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] RAW_MIN = 32'sh80000000;

  typedef struct packed {
    logic [2:0]        op;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] vs;
    logic              sat;
    logic [2:0][31:0]  mag;
    logic [2:0]        sgn;
    logic [63:0]       rem;
    logic [RootW-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [31:0]   vx;
    logic signed [31:0]   vy;
    logic signed [31:0]   vz;
    logic signed [31:0]   vs;
    logic                 sat;
    logic [2:0]           sgn;
    logic [RootW-1:0]     mg;
    logic [2:0][DivW-1:0] rem;
    logic [2:0][QuoW-1:0] quo;
  } dv_t;

  function automatic logic [32:0] clamp66(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sh7fffffff) begin
      r = {1'b1, RAW_MAX};
    end else if (v < -66'sh80000000) begin
      r = {1'b1, RAW_MIN};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

### rtl/vec3_arith_unit_top.sv
// ----------------------------------------------------------------------------
// vec3_arith_unit_top
// Three-component Q16.16 vector ALU: add, subtract, scale, dot, cross,
// magnitude and normalize, fully pipelined.
// ----------------------------------------------------------------------------
// channel  | handshake       | payload
// command  | start / busy    | op, ax, ay, az, bx, by, bz, factor
// result   | done (strobe)   | rx, ry, rz, rs, saturated
//
// One command beat is taken every cycle; busy is high only during reset.
// Every result passes through the 32 root stages of the square root and
// the 18 quotient stages of the divider.
// Reset clears the stage valid bits; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module vec3_arith_unit_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] az,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] bz,
  input  logic signed [31:0] factor,
  output logic               done,
  output logic signed [31:0] rx,
  output logic signed [31:0] ry,
  output logic signed [31:0] rz,
  output logic signed [31:0] rs,
  output logic               saturated
);

  localparam int Lat = 3 + v3alu_pkg::RootW + 1 + v3alu_pkg::QuoW + 1;

  assign busy = rst;

  // Stage 1: products and sums.
  logic                     v1;
  logic [2:0]               op1;
  logic signed [63:0]       p1 [6];
  logic signed [32:0]       as1 [3];
  logic [2:0][31:0]         m1;
  logic [2:0]               sg1;
  logic signed [31:0]       ma [6];
  logic signed [31:0]       mb [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (op)
      v3alu_pkg::OP_SCALE: begin
        ma[0] = factor; mb[0] = ax;
        ma[1] = factor; mb[1] = ay;
        ma[2] = factor; mb[2] = az;
      end
      v3alu_pkg::OP_CROSS: begin
        ma[0] = ay; mb[0] = bz;
        ma[1] = az; mb[1] = bx;
        ma[2] = ax; mb[2] = by;
        ma[3] = az; mb[3] = by;
        ma[4] = ax; mb[4] = bz;
        ma[5] = ay; mb[5] = bx;
      end
      v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM: begin
        ma[0] = ax; mb[0] = ax;
        ma[1] = ay; mb[1] = ay;
        ma[2] = az; mb[2] = az;
      end
      default: begin
        ma[0] = ax; mb[0] = bx;
        ma[1] = ay; mb[1] = by;
        ma[2] = az; mb[2] = bz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    op1 <= op;
    for (int i = 0; i < 6; i++) begin
      p1[i] <= ma[i] * mb[i];
    end
    if (op == v3alu_pkg::OP_SUB) begin
      as1[0] <= {ax[31], ax} - {bx[31], bx};
      as1[1] <= {ay[31], ay} - {by[31], by};
      as1[2] <= {az[31], az} - {bz[31], bz};
    end else begin
      as1[0] <= {ax[31], ax} + {bx[31], bx};
      as1[1] <= {ay[31], ay} + {by[31], by};
      as1[2] <= {az[31], az} + {bz[31], bz};
    end
    sg1 <= {az[31], ay[31], ax[31]};
    m1[0] <= ax[31] ? 32'(~ax + 32'sd1) : ax;
    m1[1] <= ay[31] ? 32'(~ay + 32'sd1) : ay;
    m1[2] <= az[31] ? 32'(~az + 32'sd1) : az;
  end

  // Stage 2: wide sums ahead of rounding.
  logic                     v2;
  logic [2:0]               op2;
  logic signed [65:0]       t2 [3];
  logic [63:0]              s2;
  logic signed [32:0]       as2 [3];
  logic [2:0][31:0]         m2;
  logic [2:0]               sg2;
  logic signed [65:0]       dsum;

  assign dsum = 66'(p1[0]) + 66'(p1[1]) + 66'(p1[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    op2 <= op1;
    as2 <= as1;
    m2  <= m1;
    sg2 <= sg1;
    s2  <= dsum[63:0];
    case (op1)
      v3alu_pkg::OP_DOT: begin
        t2[0] <= dsum;
        t2[1] <= '0;
        t2[2] <= '0;
      end
      v3alu_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          t2[i] <= 66'(p1[i]) - 66'(p1[i+3]);
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          t2[i] <= 66'(p1[i]);
        end
      end
    endcase
  end

  // Stage 3: rounding and clamping; seeds the square root.
  logic                     v3;
  v3alu_pkg::sq_t           sq [v3alu_pkg::RootW+1];
  logic        [2:0][32:0]  c3;
  logic signed [65:0]       u3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (op2 == v3alu_pkg::OP_ADD || op2 == v3alu_pkg::OP_SUB) begin
        u3[i] = 66'(as2[i]);
      end else begin
        u3[i] = (t2[i] + 66'sd32768) >>> 16;
      end
      c3[i] = v3alu_pkg::clamp66(u3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    sq[0].op   <= op2;
    sq[0].mag  <= m2;
    sq[0].sgn  <= sg2;
    sq[0].rem  <= s2;
    sq[0].root <= '0;
    sq[0].vx   <= '0;
    sq[0].vy   <= '0;
    sq[0].vz   <= '0;
    sq[0].vs   <= '0;
    sq[0].sat  <= 1'b0;
    case (op2)
      v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_SCALE,
      v3alu_pkg::OP_CROSS: begin
        sq[0].vx  <= c3[0][31:0];
        sq[0].vy  <= c3[1][31:0];
        sq[0].vz  <= c3[2][31:0];
        sq[0].sat <= c3[0][32] | c3[1][32] | c3[2][32];
      end
      v3alu_pkg::OP_DOT: begin
        sq[0].vs  <= c3[0][31:0];
        sq[0].sat <= c3[0][32];
      end
      default: begin
      end
    endcase
  end

  // Square root: one root bit per stage.
  logic [v3alu_pkg::RootW:0] sqv;
  assign sqv[0] = v3;

  for (genvar k = 0; k < v3alu_pkg::RootW; k++) begin : g_sqrt
    localparam int Bit = v3alu_pkg::RootW - 1 - k;
    logic [65:0] trial;
    assign trial = ({34'b0, sq[k].root} << (Bit + 1)) | (66'b1 << (2 * Bit));
    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[k+1] <= 1'b0;
      end else begin
        sqv[k+1] <= sqv[k];
      end
      sq[k+1] <= sq[k];
      if ({2'b0, sq[k].rem} >= trial) begin
        sq[k+1].rem       <= sq[k].rem - trial[63:0];
        sq[k+1].root[Bit] <= 1'b1;
      end
    end
  end

  // Root rounding and divider setup.
  localparam int Sq = v3alu_pkg::RootW;
  logic                    vr;
  v3alu_pkg::dv_t          dv [v3alu_pkg::QuoW+1];
  logic [v3alu_pkg::RootW-1:0] mgr;

  assign mgr = ({32'b0, sq[Sq].root} < sq[Sq].rem) ? sq[Sq].root + 32'd1 : sq[Sq].root;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else begin
      vr <= sqv[Sq];
    end
    dv[0].op  <= sq[Sq].op;
    dv[0].vx  <= sq[Sq].vx;
    dv[0].vy  <= sq[Sq].vy;
    dv[0].vz  <= sq[Sq].vz;
    dv[0].vs  <= sq[Sq].vs;
    dv[0].sat <= sq[Sq].sat;
    dv[0].sgn <= sq[Sq].sgn;
    dv[0].mg  <= mgr;
    dv[0].quo <= '0;
    for (int i = 0; i < 3; i++) begin
      dv[0].rem[i] <= {1'b0, sq[Sq].mag[i], 16'b0} + {18'b0, mgr[31:1]};
    end
  end

  // Divider: one quotient bit per stage in each lane.
  logic [v3alu_pkg::QuoW:0] dvv;
  assign dvv[0] = vr;

  for (genvar j = 0; j < v3alu_pkg::QuoW; j++) begin : g_div
    localparam int Bit = v3alu_pkg::QuoW - 1 - j;
    logic [v3alu_pkg::DivW:0] dsr;
    assign dsr = {18'b0, dv[j].mg} << Bit;
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[j+1] <= 1'b0;
      end else begin
        dvv[j+1] <= dvv[j];
      end
      dv[j+1] <= dv[j];
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, dv[j].rem[i]} >= dsr) begin
          dv[j+1].rem[i]      <= dv[j].rem[i] - dsr[v3alu_pkg::DivW-1:0];
          dv[j+1].quo[i][Bit] <= 1'b1;
        end
      end
    end
  end

  // Output register.
  localparam int Dq = v3alu_pkg::QuoW;
  v3alu_pkg::dv_t      fin;
  logic signed [2:0][31:0] nv;

  assign fin = dv[Dq];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fin.mg == '0) begin
        nv[i] = '0;
      end else if (fin.sgn[i]) begin
        nv[i] = -$signed({14'b0, fin.quo[i]});
      end else begin
        nv[i] = $signed({14'b0, fin.quo[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvv[Dq];
    end
    rx        <= fin.vx;
    ry        <= fin.vy;
    rz        <= fin.vz;
    rs        <= fin.vs;
    saturated <= fin.sat;
    case (fin.op)
      v3alu_pkg::OP_MAG: begin
        if (fin.mg > 32'h7fffffff) begin
          rs        <= v3alu_pkg::RAW_MAX;
          saturated <= 1'b1;
        end else begin
          rs        <= $signed(fin.mg);
          saturated <= 1'b0;
        end
      end
      v3alu_pkg::OP_NORM: begin
        rx        <= nv[0];
        ry        <= nv[1];
        rz        <= nv[2];
        rs        <= '0;
        saturated <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Lat))
    else $error("result without a matching command");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    done && (rx != 0 || ry != 0 || rz != 0) |-> rs == 0)
    else $error("vector and scalar results both nonzero");

  a_norm_nosat: assert property (@(posedge clk) disable iff (rst)
    dvv[Dq] && fin.op == v3alu_pkg::OP_NORM |=> !saturated)
    else $error("normalize result flagged as saturated");

  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    sqv[Sq] |-> sq[Sq].rem <= {31'b0, sq[Sq].root, 1'b0})
    else $error("square root remainder out of range");

endmodule

### dv/vec3_arith_unit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vec3_arith_unit_top_tb
// Self-checking bench for the Q16.16 vector unit. Commands are queued by a
// stimulus process and driven by a clocked driver with random gaps; a monitor
// compares every result beat against a local predictor of the arithmetic.
// ----------------------------------------------------------------------------
module vec3_arith_unit_top_tb;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] ax, ay, az, bx, by, bz, factor;
  } vcmd_t;

  typedef struct packed {
    logic signed [31:0] rx, ry, rz, rs;
    logic               sat;
  } vres_t;

  localparam int Latency = 55;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] op = '0;
  logic signed [31:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
  logic signed [31:0] factor = '0;
  logic done;
  logic signed [31:0] rx, ry, rz, rs;
  logic saturated;

  vcmd_t pending_cmds[$];
  vres_t expected_res[$];
  int unsigned mismatches = 0;
  int unsigned result_count = 0;
  int unsigned op_count[8];
  int unsigned cycle_count = 0;
  int gap_left = 0;
  bit gaps_on = 1'b1;
  bit hold_sender = 1'b0;

  vec3_arith_unit_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz), .factor(factor),
    .done(done), .rx(rx), .ry(ry), .rz(rz), .rs(rs), .saturated(saturated)
  );

  always #10 clk = ~clk;

  function automatic logic signed [31:0] clamp_q(input logic signed [127:0] v,
                                                 inout logic sat);
    if (v > 128'sh7fffffff) begin
      sat = 1'b1;
      return v3alu_pkg::RAW_MAX;
    end
    if (v < -128'sh80000000) begin
      sat = 1'b1;
      return v3alu_pkg::RAW_MIN;
    end
    return v[31:0];
  endfunction

  // Exact Q32.32 sum rounded half up to Q16.16, then clamped.
  function automatic logic signed [31:0] round_q(input logic signed [127:0] p,
                                                 inout logic sat);
    logic signed [127:0] t;
    t = (p + 128'sd32768) >>> 16;
    return clamp_q(t, sat);
  endfunction

  function automatic logic [63:0] mag_of(input vcmd_t c);
    logic [63:0] s, r, m0, m1, m2, bit_v, n;
    m0 = c.ax < 0 ? -64'(c.ax) : 64'(c.ax);
    m1 = c.ay < 0 ? -64'(c.ay) : 64'(c.ay);
    m2 = c.az < 0 ? -64'(c.az) : 64'(c.az);
    s = m0 * m0 + m1 * m1 + m2 * m2;
    n = s;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic vres_t vector_result(input vcmd_t c);
    vres_t e;
    logic signed [127:0] a[3], b[3], k;
    logic [63:0] mg, m, q;
    int j, n;
    e = '0;
    a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
    b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
    k = c.factor;
    case (c.op)
      v3alu_pkg::OP_ADD: begin
        e.rx = clamp_q(a[0] + b[0], e.sat);
        e.ry = clamp_q(a[1] + b[1], e.sat);
        e.rz = clamp_q(a[2] + b[2], e.sat);
      end
      v3alu_pkg::OP_SUB: begin
        e.rx = clamp_q(a[0] - b[0], e.sat);
        e.ry = clamp_q(a[1] - b[1], e.sat);
        e.rz = clamp_q(a[2] - b[2], e.sat);
      end
      v3alu_pkg::OP_SCALE: begin
        e.rx = round_q(k * a[0], e.sat);
        e.ry = round_q(k * a[1], e.sat);
        e.rz = round_q(k * a[2], e.sat);
      end
      v3alu_pkg::OP_DOT:
        e.rs = round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], e.sat);
      v3alu_pkg::OP_CROSS: begin
        e.rx = round_q(a[1] * b[2] - a[2] * b[1], e.sat);
        e.ry = round_q(a[2] * b[0] - a[0] * b[2], e.sat);
        e.rz = round_q(a[0] * b[1] - a[1] * b[0], e.sat);
      end
      v3alu_pkg::OP_MAG: begin
        mg = mag_of(c);
        if (mg > 64'h7fffffff) begin
          e.sat = 1'b1;
          mg = 64'h7fffffff;
        end
        e.rs = mg[31:0];
      end
      v3alu_pkg::OP_NORM: begin
        mg = mag_of(c);
        if (mg != 0) begin
          logic signed [31:0] v[3];
          for (j = 0; j < 3; j++) begin
            m = a[j] < 0 ? 64'(-a[j]) : 64'(a[j]);
            q = ((m << 16) + (mg >> 1)) / mg;
            v[j] = clamp_q(a[j] < 0 ? -128'(q) : 128'(q), e.sat);
          end
          e.rx = v[0]; e.ry = v[1]; e.rz = v[2];
        end
      end
      default: n = 0;
    endcase
    return e;
  endfunction

  function automatic logic signed [31:0] rand_comp(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0007ffff)) - 32'sh00040000;
      2: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
      3: return $urandom_range(0, 1) ? v3alu_pkg::RAW_MAX : v3alu_pkg::RAW_MIN;
      default: return $signed($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  task automatic queue_cmd(input logic [2:0] o, input logic signed [31:0] a0,
                           a1, a2, b0, b1, b2, k);
    vcmd_t c;
    c.op = o; c.ax = a0; c.ay = a1; c.az = a2;
    c.bx = b0; c.by = b1; c.bz = b2; c.factor = k;
    pending_cmds.push_back(c);
  endtask

  // Driver: one command beat per accepted cycle, with random idle bursts.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        op_count[op] <= op_count[op] + 1;
        expected_res.push_back(vector_result({op, ax, ay, az, bx, by, bz, factor}));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0 && !hold_sender) begin
        vcmd_t c;
        c = pending_cmds.pop_front();
        {op, ax, ay, az, bx, by, bz, factor} <= c;
        start <= 1'b1;
        if (gaps_on && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 9);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each done beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      vres_t e, got;
      got = {rx, ry, rz, rs, saturated};
      result_count <= result_count + 1;
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %h", got);
      end else begin
        e = expected_res.pop_front();
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp rx=%h ry=%h rz=%h rs=%h sat=%b, got rx=%h ry=%h rz=%h rs=%h sat=%b",
                     e.rx, e.ry, e.rz, e.rs, e.sat,
                     got.rx, got.ry, got.rz, got.rs, got.sat);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("Timeout with %0d results outstanding.", expected_res.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int i, mode;
    logic [2:0] o;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    queue_cmd(v3alu_pkg::OP_ADD, v3alu_pkg::RAW_MAX, v3alu_pkg::RAW_MIN, 32'sh10000,
              1, -1, 32'sh10000, 0);
    queue_cmd(v3alu_pkg::OP_ADD, -1, 0, 5, -1, 0, 7, 0);
    queue_cmd(v3alu_pkg::OP_SUB, v3alu_pkg::RAW_MIN, v3alu_pkg::RAW_MAX, 0, 1, -1,
              v3alu_pkg::RAW_MIN, 0);
    queue_cmd(v3alu_pkg::OP_SUB, 3, -3, 0, 3, 3, 0, 0);
    queue_cmd(v3alu_pkg::OP_SCALE, 32'sh18000, -32'sh8000, 1, 0, 0, 0, 32'sh8000);
    queue_cmd(v3alu_pkg::OP_SCALE, v3alu_pkg::RAW_MAX, v3alu_pkg::RAW_MIN, -1, 0, 0, 0,
              v3alu_pkg::RAW_MIN);
    queue_cmd(v3alu_pkg::OP_SCALE, 1, -1, 3, 0, 0, 0, 32'sh8000);
    queue_cmd(v3alu_pkg::OP_DOT, v3alu_pkg::RAW_MAX, v3alu_pkg::RAW_MAX,
              v3alu_pkg::RAW_MAX, v3alu_pkg::RAW_MAX, v3alu_pkg::RAW_MAX,
              v3alu_pkg::RAW_MAX, 0);
    queue_cmd(v3alu_pkg::OP_DOT, 32'sh10000, 32'sh20000, -32'sh30000, 32'sh4000, 1, 7, 0);
    queue_cmd(v3alu_pkg::OP_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0);
    queue_cmd(v3alu_pkg::OP_CROSS, v3alu_pkg::RAW_MIN, v3alu_pkg::RAW_MAX,
              v3alu_pkg::RAW_MIN, v3alu_pkg::RAW_MAX, v3alu_pkg::RAW_MIN,
              v3alu_pkg::RAW_MAX, 0);
    queue_cmd(v3alu_pkg::OP_MAG, 32'sh30000, 32'sh40000, 0, 0, 0, 0, 0);
    queue_cmd(v3alu_pkg::OP_MAG, v3alu_pkg::RAW_MIN, v3alu_pkg::RAW_MIN,
              v3alu_pkg::RAW_MIN, 0, 0, 0, 0);
    queue_cmd(v3alu_pkg::OP_MAG, 0, 0, 0, 0, 0, 0, 0);
    queue_cmd(v3alu_pkg::OP_NORM, 0, 0, 0, -1, -1, -1, -1);
    queue_cmd(v3alu_pkg::OP_NORM, 32'sh30000, -32'sh40000, 0, 0, 0, 0, 0);
    queue_cmd(v3alu_pkg::OP_NORM, v3alu_pkg::RAW_MIN, 0, 0, 0, 0, 0, 0);
    queue_cmd(v3alu_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0);
    queue_cmd(v3alu_pkg::OP_NORM, -1, 1, 1, 0, 0, 0, 0);
    queue_cmd(3'd7, v3alu_pkg::RAW_MAX, v3alu_pkg::RAW_MIN, -1, -1, v3alu_pkg::RAW_MIN,
              v3alu_pkg::RAW_MAX, -1);
    wait (pending_cmds.size() == 0 && !start);
    // Let the pipeline drain completely before the random part.
    hold_sender = 1'b1;
    wait (expected_res.size() == 0);
    hold_sender = 1'b0;
    for (i = 0; i < 1850; i++) begin
      mode = $urandom_range(0, 4);
      o = $urandom_range(0, 15) == 0 ? 3'd7 : 3'($urandom_range(0, 6));
      queue_cmd(o, rand_comp(mode), rand_comp(mode), rand_comp(mode),
                rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode));
      if (i == 1500) begin
        wait (pending_cmds.size() < 4);
        gaps_on = 1'b0;
      end
    end
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_res.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    $display("Covered %0d results: add %0d, sub %0d, scale %0d, dot %0d, cross %0d,",
             result_count, op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4]);
    $display("magnitude %0d, normalize %0d, unused opcode %0d; %0d mismatches.",
             op_count[5], op_count[6], op_count[7], mismatches);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
